// ===== design/timestamped_frame_queue_assert.svh =====
// Assertion macros shared by the frame queue RTL.
// Expects clk and rst_n in the including module's scope.
`ifndef TIMESTAMPED_FRAME_QUEUE_ASSERT_SVH
`define TIMESTAMPED_FRAME_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame queue assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TFQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame queue assertion failed");

`endif

// ===== design/tfq_pkg.sv =====
// Package for the timestamped frame queue: sizes, op codes, sequencer states.
// No dependencies.
package tfq_pkg;

    localparam int DEPTH   = 8;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int LVL_W   = $clog2(DEPTH + 1);
    localparam int STAMP_W = 32;
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 3;
    localparam int DROP_W  = 3;
    localparam int LEVEL_W = 4;
    localparam int ENTRY_W = STAMP_W + 1;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [LVL_W-1:0] lvl_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_QUERY = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_QREAD,
        S_QCHECK,
        S_DONE
    } state_t;

    function automatic ptr_t next_ptr(input ptr_t p);
        next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
    endfunction

endpackage

// ===== design/tfq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/timestamped_frame_queue.sv =====
// Timestamped frame queue with late drop: ring control, sequencer, result registers.
// Depends on tfq_pkg, tfq_ram and timestamped_frame_queue_assert.svh.
//
// Channel   Handshake            Payload
// command   start & !busy        op, stamp, stamp_known
// result    done (one cycle)     accepted, slot, shown_stamp, shown_known,
//                                dropped, level_after
//
// Push, flush and unused op go from accept straight to S_DONE.
// Query: one S_QREAD/S_QCHECK pair per dropped frame and per check after them (1 or 2),
// then S_DONE; a query on an empty ring goes from S_QREAD straight to S_DONE.
// Each slot visit costs one RAM read and one pass through the shared compare.
// busy is high from the accept edge until the cycle after done.
// Reset clears pointers and level; slot contents are undefined until pushed.
// The receiver cannot stall; done is high for one cycle, results hold to the next accept.
`include "timestamped_frame_queue_assert.svh"

module timestamped_frame_queue
    import tfq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    op,
    input  logic [STAMP_W-1:0] stamp,
    input  logic               stamp_known,
    output logic               done,
    output logic               accepted,
    output logic [SLOT_W-1:0]  slot,
    output logic [STAMP_W-1:0] shown_stamp,
    output logic               shown_known,
    output logic [DROP_W-1:0]  dropped,
    output logic [LEVEL_W-1:0] level_after
);

    state_t state_reg, state_next;

    ptr_t   wptr_reg, wptr_next;
    ptr_t   rptr_reg, rptr_next;
    lvl_t   level_reg, level_next;
    logic   front_mode_reg, front_mode_next;

    logic [OP_W-1:0]    op_reg, op_next;
    logic [STAMP_W-1:0] time_reg, time_next;

    logic               accepted_reg, accepted_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [STAMP_W-1:0] shown_stamp_reg, shown_stamp_next;
    logic               shown_known_reg, shown_known_next;
    logic [DROP_W-1:0]  dropped_reg, dropped_next;

    logic               cmd_accept;
    logic               push_ok;
    logic               rd_front;
    logic               ram_we;
    ptr_t               ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [STAMP_W-1:0] rd_stamp;
    logic               rd_known;
    logic               stamp_due;

    assign cmd_accept = start && !busy;
    assign push_ok    = (op == OP_PUSH) && (level_reg < LVL_W'(DEPTH));
    assign rd_front   = front_mode_reg || (level_reg < LVL_W'(2));
    assign rd_stamp   = ram_rdata[STAMP_W-1:0];
    assign rd_known   = ram_rdata[STAMP_W];
    // shared compare unit: used for both the drop test and the front test
    assign stamp_due  = (rd_stamp <= time_reg);

    tfq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata ({stamp_known, stamp}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    state_next = (op == OP_QUERY) ? S_QREAD : S_DONE;
                end
            end
            S_QREAD:
            begin
                state_next = (level_reg == '0) ? S_DONE : S_QCHECK;
            end
            S_QCHECK:
            begin
                state_next = front_mode_reg ? S_DONE : S_QREAD;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        busy      = 1'b1;
        done      = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = rptr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                busy   = 1'b0;
                ram_we = cmd_accept && push_ok;
            end
            S_QREAD:
            begin
                ram_raddr = rd_front ? rptr_reg : next_ptr(rptr_reg);
            end
            S_QCHECK:
            begin
                ram_raddr = rptr_reg;
            end
            S_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // ring and result datapath
    always_comb
    begin
        wptr_next        = wptr_reg;
        rptr_next        = rptr_reg;
        level_next       = level_reg;
        front_mode_next  = front_mode_reg;
        op_next          = op_reg;
        time_next        = time_reg;
        accepted_next    = accepted_reg;
        slot_next        = slot_reg;
        shown_stamp_next = shown_stamp_reg;
        shown_known_next = shown_known_reg;
        dropped_next     = dropped_reg;

        if (state_reg == S_IDLE && cmd_accept)
        begin
            op_next          = op;
            time_next        = stamp;
            accepted_next    = 1'b0;
            slot_next        = '0;
            shown_stamp_next = '0;
            shown_known_next = 1'b0;
            dropped_next     = '0;
            front_mode_next  = 1'b0;
            unique case (op)
                OP_PUSH:
                begin
                    if (push_ok)
                    begin
                        accepted_next = 1'b1;
                        slot_next     = SLOT_W'(wptr_reg);
                        wptr_next     = next_ptr(wptr_reg);
                        level_next    = lvl_t'(level_reg + 1'b1);
                    end
                end
                OP_FLUSH:
                begin
                    accepted_next = 1'b1;
                    wptr_next     = '0;
                    rptr_next     = '0;
                    level_next    = '0;
                end
                OP_QUERY:
                begin
                    accepted_next = 1'b0;
                end
                default:
                begin
                    accepted_next = 1'b0;
                end
            endcase
        end
        else if (state_reg == S_QREAD)
        begin
            front_mode_next = rd_front;
        end
        else if (state_reg == S_QCHECK)
        begin
            if (front_mode_reg)
            begin
                if (!rd_known || stamp_due)
                begin
                    accepted_next    = 1'b1;
                    slot_next        = SLOT_W'(rptr_reg);
                    shown_stamp_next = rd_stamp;
                    shown_known_next = rd_known;
                    rptr_next        = next_ptr(rptr_reg);
                    level_next       = lvl_t'(level_reg - 1'b1);
                end
            end
            else if (rd_known && stamp_due)
            begin
                // frame behind the front is already due: drop the front
                rptr_next    = next_ptr(rptr_reg);
                level_next   = lvl_t'(level_reg - 1'b1);
                dropped_next = DROP_W'(dropped_reg + 1'b1);
            end
            else
            begin
                front_mode_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wptr_reg       <= '0;
            rptr_reg       <= '0;
            level_reg      <= '0;
            front_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wptr_reg       <= wptr_next;
            rptr_reg       <= rptr_next;
            level_reg      <= level_next;
            front_mode_reg <= front_mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        time_reg        <= time_next;
        accepted_reg    <= accepted_next;
        slot_reg        <= slot_next;
        shown_stamp_reg <= shown_stamp_next;
        shown_known_reg <= shown_known_next;
        dropped_reg     <= dropped_next;
    end

    assign accepted    = accepted_reg;
    assign slot        = slot_reg;
    assign shown_stamp = shown_stamp_reg;
    assign shown_known = shown_known_reg;
    assign dropped     = dropped_reg;
    assign level_after = LEVEL_W'(level_reg);

    `TFQ_ASSERT_IMPL(a_level_bound, 1'b1, level_reg <= LVL_W'(DEPTH))
    `TFQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `TFQ_ASSERT_NEXT(a_query_no_grow, state_reg == S_QCHECK, level_reg <= $past(level_reg))
    `TFQ_ASSERT_IMPL(a_flush_empty, done && op_reg == OP_FLUSH,
        accepted_reg && level_reg == '0)
    `TFQ_ASSERT_IMPL(a_push_level, done && op_reg == OP_PUSH && accepted_reg,
        level_reg != '0)

endmodule
